### design/piecewise_linear_table_interp_defines.svh
// Assertion macros for the interpolation table RTL
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLTI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PLTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/plti_pkg.sv
// Constants shared by the interpolation table modules
package plti_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);

    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

### design/piecewise_linear_table_interp.sv
// Piecewise-linear interpolation table over signed Q16.16 breakpoints
//
// Requests are taken when start is high and busy is low; action selects
// query (0), append breakpoint (1) or clear (2). Every request gives one
// result on o_result_value/o_status, marked by o_strobe for one cycle.
// Append, clear, unused actions and queries of an empty table answer in the
// cycle after the request and never raise busy.
// A one-point table answers through the V0RD and V1RD states. Otherwise a
// query reads the key memory one breakpoint at a time, starting at the
// cached interval and going back to the first point if that key lies
// above the query; a query on or outside the found interval is clamped
// to that interval's end value. A query strictly inside an interval
// then runs the divider at one fraction bit per cycle, waits to see it
// done, then does one multiply and one add.
// busy stays high until the result strobe.
// Reset empties the table and zeroes the cached interval; memory contents
// are left as they are. The receiver cannot stall: results are not held.
`include "piecewise_linear_table_interp_defines.svh"
module piecewise_linear_table_interp import plti_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_key_time,
    input  logic signed [DATA_W-1:0] i_point_value,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_status
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int PW     = CW + 1;
    localparam int PROD_W = FRAC_BITS + 1 + DATA_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KRD, ST_KCHK, ST_NRD, ST_NCHK,
        ST_V0RD, ST_V1RD, ST_V1CAP, ST_DIV, ST_MUL, ST_ADD
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_spos;
    logic [AW-1:0]            r_pos;
    logic                     r_single;
    logic signed [DATA_W-1:0] r_q;
    logic signed [DATA_W-1:0] r_k0;
    logic signed [DATA_W-1:0] r_k1;
    logic signed [DATA_W-1:0] r_v0;
    logic signed [DATA_W:0]   r_dv;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_strobe;
    logic signed [DATA_W-1:0] r_result;
    logic                     r_status;

    logic                     accept;
    logic                     we;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_key;
    logic [DATA_W-1:0]        rd_val;
    logic                     div_start;
    logic                     div_done;
    logic [FRAC_BITS-1:0]     div_quo;
    logic signed [DATA_W:0]   num_diff;
    logic signed [DATA_W:0]   den_diff;
    logic signed [DATA_W:0]   val_diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W:0]   sum;
    logic [AW-1:0]            start_pos;
    logic                     walk_on;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign we     = accept && (i_action == ACT_APPEND) && (r_count != DEPTH_C);

    assign start_pos = ((PW'(r_spos) + PW'(1)) >= PW'(r_count)) ? '0 : r_spos;
    assign walk_on   = ($signed(rd_key) < r_q) && ((PW'(r_pos) + PW'(2)) < PW'(r_count));

    assign num_diff  = {r_q[DATA_W-1], r_q} - {r_k0[DATA_W-1], r_k0};
    assign den_diff  = {r_k1[DATA_W-1], r_k1} - {r_k0[DATA_W-1], r_k0};
    assign val_diff  = {rd_val[DATA_W-1], rd_val} - {r_v0[DATA_W-1], r_v0};
    assign div_start = (r_state == ST_V1CAP) && (r_q > r_k0) && (r_q < r_k1);
    assign prod      = $signed({1'b0, div_quo}) * r_dv;
    assign sum       = {r_v0[DATA_W-1], r_v0} + r_prod[FRAC_BITS +: DATA_W + 1];

    always_comb begin
        unique case (r_state)
            ST_NRD, ST_V1RD: rd_addr = r_pos + AW'(1);
            default:         rd_addr = r_pos;
        endcase
    end

    plti_store #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wkey  (i_key_time),
        .i_wval  (i_point_value),
        .i_raddr (rd_addr),
        .o_rkey  (rd_key),
        .o_rval  (rd_val)
    );

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_diff[DATA_W-1:0]),
        .i_den   (den_diff[DATA_W-1:0]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_spos   <= '0;
            r_pos    <= '0;
            r_single <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_q      <= i_key_time;
                        r_result <= '0;
                        r_status <= STATUS_OK;
                        unique case (i_action)
                            ACT_QUERY: begin
                                if (r_count == '0) begin
                                    r_strobe <= 1'b1;
                                end else if (r_count == CW'(1)) begin
                                    r_single <= 1'b1;
                                    r_pos    <= '0;
                                    r_state  <= ST_V0RD;
                                end else begin
                                    r_single <= 1'b0;
                                    r_pos    <= start_pos;
                                    r_state  <= ST_KRD;
                                end
                            end
                            ACT_APPEND: begin
                                if (r_count == DEPTH_C) begin
                                    r_status <= STATUS_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_strobe <= 1'b1;
                            end
                            ACT_CLEAR: begin
                                r_count  <= '0;
                                r_spos   <= '0;
                                r_strobe <= 1'b1;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_KRD: r_state <= ST_KCHK;
                ST_KCHK: begin
                    if (($signed(rd_key) > r_q) && (r_pos != '0)) begin
                        r_pos   <= '0;
                        r_state <= ST_KRD;
                    end else begin
                        r_k0    <= $signed(rd_key);
                        r_state <= ST_NRD;
                    end
                end
                ST_NRD: r_state <= ST_NCHK;
                ST_NCHK: begin
                    if (walk_on) begin
                        r_k0    <= $signed(rd_key);
                        r_pos   <= r_pos + AW'(1);
                        r_state <= ST_NRD;
                    end else begin
                        r_k1    <= $signed(rd_key);
                        r_spos  <= r_pos;
                        r_state <= ST_V0RD;
                    end
                end
                ST_V0RD: r_state <= ST_V1RD;
                ST_V1RD: begin
                    r_v0 <= $signed(rd_val);
                    if (r_single) begin
                        r_result <= $signed(rd_val);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_V1CAP;
                    end
                end
                ST_V1CAP: begin
                    r_dv <= val_diff;
                    if (r_q <= r_k0) begin
                        r_result <= r_v0;
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else if (r_q >= r_k1) begin
                        r_result <= $signed(rd_val);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= prod;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_result <= sum[DATA_W-1:0];
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_result;
    assign o_status       = r_status;

    `PLTI_ASSERT_IMPL(a_strobe_idle, r_strobe, !busy, "result strobe while busy")
    `PLTI_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= DEPTH_C, "point count above depth")
    `PLTI_ASSERT_IMPL(a_spos_room, r_spos != '0, (PW'(r_spos) + PW'(1)) < PW'(r_count),
        "cached interval has no next point")
    `PLTI_ASSERT_IMPL(a_div_in_div, div_done, r_state == ST_DIV, "divider done outside wait")
    `PLTI_ASSERT_NEXT(a_accept_moves, accept && (i_action != ACT_QUERY), r_strobe,
        "non-query request without result")

endmodule

### design/plti_store.sv
// Breakpoint key and value memories, one write and one registered read port
module plti_store import plti_pkg::*; #(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wkey,
    input  logic [DATA_W-1:0] i_wval,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rkey,
    output logic [DATA_W-1:0] o_rval
);

    logic [DATA_W-1:0] r_key_mem [2**AW];
    logic [DATA_W-1:0] r_val_mem [2**AW];
    logic [DATA_W-1:0] r_rkey;
    logic [DATA_W-1:0] r_rval;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr] <= i_wkey;
            r_val_mem[i_waddr] <= i_wval;
        end
        r_rkey <= r_key_mem[i_raddr];
        r_rval <= r_val_mem[i_raddr];
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;

endmodule

### design/plti_div.sv
// Restoring divider, one quotient bit per cycle, fraction of a proper quotient
module plti_div import plti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DATA_W-1:0]    i_num,
    input  logic [DATA_W-1:0]    i_den,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quo
);

    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_den;
    logic [FRAC_BITS-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [DATA_W:0]      rem2;
    logic                 ge;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_cnt  <= DIV_CNT_W'(FRAC_BITS - 1);
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run) begin
            r_rem  <= ge ? DATA_W'(rem2 - {1'b0, r_den}) : rem2[DATA_W-1:0];
            r_quo  <= {r_quo[FRAC_BITS-2:0], ge};
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
            r_run  <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### verif/tb_piecewise_linear_table_interp.sv
// Self-checking testbench for the piecewise-linear interpolation table
module tb_piecewise_linear_table_interp import plti_pkg::*; ();

    localparam int         DEPTH       = 256;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         N_DIR       = 26;
    localparam int         TOTAL_ITEMS = N_DIR + 1100;
    localparam int         QUIET_FROM  = TOTAL_ITEMS - 120;
    localparam bit         PIN         = 1'b1;
    localparam bit         CALC        = 1'b0;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] key;
        logic [31:0] val;
        bit          pinned;
        logic [31:0] want_val;
        logic        want_st;
    } t_dir_row;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } t_answer;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     start         = 1'b0;
    logic                     busy;
    logic [1:0]               i_action      = ACT_QUERY;
    logic signed [DATA_W-1:0] i_key_time    = '0;
    logic signed [DATA_W-1:0] i_point_value = '0;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_status;

    logic signed [31:0] bp_key [DEPTH];
    logic signed [31:0] bp_val [DEPTH];
    int unsigned        n_points   = 0;
    int unsigned        cached_pos = 0;

    t_answer answers_due [$];
    int      sent       = 0;
    int      mismatches = 0;
    bit      filled     = 1'b0;

    t_dir_row dir_rows [N_DIR] = '{
        '{ACT_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h7FFF_FFFF, 32'h0000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h8000_0000, 32'h0000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h8000_0000, 32'h0000_0000, PIN,  32'h7FFF_FFFF, STATUS_OK},
        '{ACT_QUERY,  32'h7FFF_FFFF, 32'h0000_0000, PIN,  32'h7FFF_FFFF, STATUS_OK},
        '{ACT_APPEND, 32'h0003_0000, 32'h8000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h0002_0000, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h0001_8000, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h8000_0000, 32'h0000_0000, PIN,  32'h7FFF_FFFF, STATUS_OK},
        '{ACT_QUERY,  32'h7FFF_FFFF, 32'h0000_0000, PIN,  32'h8000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h0001_0000, 32'h0000_0000, PIN,  32'h7FFF_FFFF, STATUS_OK},
        '{ACT_QUERY,  32'h0003_0000, 32'h0000_0000, PIN,  32'h8000_0000, STATUS_OK},
        '{ACT_APPEND, 32'h8000_0000, 32'h1234_5678, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h0005_0000, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h0000_0000, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK},
        '{ACT_APPEND, 32'h7FFF_FFFF, 32'h0000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h7FFF_FFFE, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK},
        '{ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h1234_5678, 32'h0000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_APPEND, 32'h8000_0000, 32'h8000_0000, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, PIN,  32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h0000_0000, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK},
        '{ACT_QUERY,  32'h8000_0001, 32'h0000_0000, CALC, 32'h0000_0000, STATUS_OK}
    };

    piecewise_linear_table_interp #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key_time    (i_key_time),
        .i_point_value (i_point_value),
        .o_strobe      (o_strobe),
        .o_result_value(o_result_value),
        .o_status      (o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] to_q16(input longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // interpolated value at q; moves the cached interval as the block does
    function automatic logic [31:0] lookup_value(input logic signed [31:0] q);
        int unsigned pos;
        longint      qk, lo_key, hi_key, frac, v0, v1, prod;
        qk = q;
        if (n_points == 0) return '0;
        if (n_points == 1) return bp_val[0];
        pos = cached_pos;
        if (pos + 1 >= n_points) pos = 0;
        lo_key = bp_key[pos];
        if (lo_key > qk && pos > 0) begin
            pos    = 0;
            lo_key = bp_key[0];
        end
        hi_key = bp_key[pos+1];
        while (hi_key < qk && pos + 2 < n_points) begin
            lo_key = hi_key;
            hi_key = bp_key[pos+2];
            pos++;
        end
        cached_pos = pos;
        if (qk <= lo_key) return bp_val[pos];
        if (qk >= hi_key) return bp_val[pos+1];
        frac = ((qk - lo_key) <<< 16) / (hi_key - lo_key);
        v0   = bp_val[pos];
        v1   = bp_val[pos+1];
        prod = frac * (v1 - v0);
        return to_q16(v0 + (prod >>> 16));
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    task automatic issue(input logic [1:0] act, input logic [31:0] key, input logic [31:0] val,
                         input bit pinned = 1'b0, input logic [31:0] want_val = '0,
                         input logic want_st = STATUS_OK);
        t_answer ans;
        start         <= 1'b1;
        i_action      <= act;
        i_key_time    <= key;
        i_point_value <= val;
        do @(posedge i_clk); while (busy);
        ans.value  = '0;
        ans.status = STATUS_OK;
        case (act)
            ACT_QUERY: ans.value = lookup_value(key);
            ACT_APPEND: begin
                if (n_points >= DEPTH) begin
                    ans.status = STATUS_FULL;
                end else begin
                    bp_key[n_points] = key;
                    bp_val[n_points] = val;
                    n_points++;
                end
            end
            ACT_CLEAR: begin
                n_points   = 0;
                cached_pos = 0;
            end
            default: ;
        endcase
        if (pinned) begin
            ans.value  = want_val;
            ans.status = want_st;
        end
        answers_due.push_back(ans);
        sent++;
        if (sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic append_run(input int n, input bit ordered, input int step_bits);
        longint k;
        if (n_points > 0) k = bp_key[n_points-1];
        else k = longint'($signed($urandom)) >>> $urandom_range(0, 12);
        repeat (n) begin
            if (!ordered) k = $signed($urandom);
            else if ($urandom_range(0, 5) != 0)
                k += $urandom_range(1, 32'h1 << $urandom_range(4, step_bits));
            issue(ACT_APPEND, to_q16(k), $urandom);
        end
    endtask

    task automatic query_run(input int m);
        longint lo, hi, margin, span, q;
        int     style;
        if (n_points == 0) begin
            lo = -262144;
            hi = 262144;
        end else begin
            lo = bp_key[0];
            hi = bp_key[n_points-1];
            if (lo > hi) begin
                q  = lo;
                lo = hi;
                hi = q;
            end
        end
        margin = (hi - lo) / 8 + 16;
        span   = hi - lo + 2 * margin;
        for (int i = 0; i < m; i++) begin
            style = $urandom_range(0, 9);
            if (style < 6) q = lo - margin + span * i / m + $urandom_range(0, 15);
            else if (style < 8) q = lo - margin + longint'($urandom) % (span + 1);
            else if (style == 8 && n_points > 0)
                q = longint'(bp_key[$urandom_range(0, n_points - 1)]) + $urandom_range(0, 2) - 1;
            else q = $signed($urandom);
            issue(ACT_QUERY, to_q16(q), $urandom);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (answers_due.size() == 0) begin
                flag_mismatch("result with nothing pending", o_result_value, '0);
            end else begin
                t_answer exp_ans;
                exp_ans = answers_due.pop_front();
                if (o_result_value !== exp_ans.value)
                    flag_mismatch("result_value", o_result_value, exp_ans.value);
                if (o_status !== exp_ans.status)
                    flag_mismatch("status", {31'b0, o_status}, {31'b0, exp_ans.status});
            end
        end
    end

    initial begin
        int kind;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++)
            issue(dir_rows[r].act, dir_rows[r].key, dir_rows[r].val, dir_rows[r].pinned,
                  dir_rows[r].want_val, dir_rows[r].want_st);

        while (sent < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (!filled && sent >= 400) begin
                // fill past capacity, then walk the whole table
                filled = 1'b1;
                issue(ACT_CLEAR, $urandom, $urandom);
                append_run(DEPTH + 4, 1'b1, 16);
                query_run(12);
            end else if (kind < 6) begin
                if ($urandom_range(0, 3) != 0) issue(ACT_CLEAR, $urandom, $urandom);
                append_run(($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                       : $urandom_range(1, 8), 1'b1, 22);
                query_run($urandom_range(3, 12));
            end else if (kind == 6) begin
                append_run($urandom_range(1, 4), 1'b1, 22);
                query_run($urandom_range(2, 8));
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 4))
                    issue(2'($urandom_range(0, 3)), $urandom, $urandom);
            end else if (kind == 8) begin
                append_run($urandom_range(1, 6), 1'b0, 4);
                query_run($urandom_range(2, 6));
            end else begin
                issue(ACT_CLEAR, $urandom, $urandom);
                query_run($urandom_range(1, 2));
                append_run($urandom_range(0, 1), 1'b1, 22);
                query_run($urandom_range(1, 3));
            end
        end
        start <= 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
